FILE: rtl/jgvl_pkg.sv
// Shared types and constants for the jittered grid Voronoi lookup unit.
`timescale 1ns / 1ps

package jgvl_pkg;

    localparam int DEFAULT_MAX_COLUMNS   = 64;
    localparam int DEFAULT_MAX_ROWS      = 64;
    localparam int DEFAULT_FRACTION_BITS = 8;

    localparam int QUERY_W          = 21;
    localparam int INDEX_W          = 12;
    localparam int JITTER_W         = 8;
    localparam int TYPE_W           = 8;
    localparam int JITTER_FRAC_BITS = 8;
    localparam int CFG_DATA_W       = 7;
    localparam int CFG_INDEX_W      = 2;

    localparam logic [CFG_DATA_W-1:0]  GRID_SIZE_RESET = 7'd64;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    localparam logic [1:0] CORNER_UL = 2'd0;
    localparam logic [1:0] CORNER_UR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef struct packed {
        logic valid;
        logic is_load;
    } t_ctl;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [JITTER_W-1:0] jitter_x;
        logic [JITTER_W-1:0] jitter_y;
        logic [TYPE_W-1:0]   entry_type;
    } t_load;

    typedef struct packed {
        logic [TYPE_W-1:0]   entry_type;
        logic [JITTER_W-1:0] jitter_x;
        logic [JITTER_W-1:0] jitter_y;
    } t_point;

endpackage

FILE: rtl/jgvl_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module jgvl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/jgvl_wrap.sv
// Coordinate wrap pipeline: floor modulo of the cell index, one quotient bit per stage.
`timescale 1ns / 1ps

module jgvl_wrap #(
    parameter int MAX_COLUMNS   = jgvl_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS      = jgvl_pkg::DEFAULT_MAX_ROWS,
    parameter int FRACTION_BITS = jgvl_pkg::DEFAULT_FRACTION_BITS,
    localparam int XW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1,
    localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int WW = $clog2(MAX_COLUMNS + 1),
    localparam int HW = $clog2(MAX_ROWS + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  jgvl_pkg::t_ctl                          i_ctl,
    input  jgvl_pkg::t_load                         i_load,
    input  logic signed [jgvl_pkg::QUERY_W-1:0]     i_query_x,
    input  logic signed [jgvl_pkg::QUERY_W-1:0]     i_query_y,
    input  logic [WW-1:0]                           i_width,
    input  logic [HW-1:0]                           i_height,
    output jgvl_pkg::t_ctl                          o_ctl,
    output jgvl_pkg::t_load                         o_load,
    output logic [XW-1:0]                           o_cell_x,
    output logic [XW-1:0]                           o_next_x,
    output logic [YW-1:0]                           o_cell_y,
    output logic [YW-1:0]                           o_next_y,
    output logic [FRACTION_BITS-1:0]                o_frac_x,
    output logic [FRACTION_BITS-1:0]                o_frac_y
);

    localparam int QW = jgvl_pkg::QUERY_W;
    localparam int MW = QW - 1 - FRACTION_BITS;
    localparam int XP = XW + 1;
    localparam int YP = YW + 1;

    // remainder step: shift in one bit, subtract the size when it fits
    function automatic logic [XW-1:0] f_step_x(input logic [XW-1:0] rem, input logic b,
                                               input logic [WW-1:0] size);
        logic [XP-1:0] t;
        t = {rem, b};
        if (t >= XP'(size)) begin
            t = t - XP'(size);
        end
        return t[XW-1:0];
    endfunction

    function automatic logic [YW-1:0] f_step_y(input logic [YW-1:0] rem, input logic b,
                                               input logic [HW-1:0] size);
        logic [YP-1:0] t;
        t = {rem, b};
        if (t >= YP'(size)) begin
            t = t - YP'(size);
        end
        return t[YW-1:0];
    endfunction

    jgvl_pkg::t_ctl    r_ctl    [0:MW];
    jgvl_pkg::t_load   r_load   [0:MW];
    logic [MW-1:0]     r_mag_x  [0:MW];
    logic [MW-1:0]     r_mag_y  [0:MW];
    logic              r_neg_x  [0:MW];
    logic              r_neg_y  [0:MW];
    logic [FRACTION_BITS-1:0] r_frac_x [0:MW];
    logic [FRACTION_BITS-1:0] r_frac_y [0:MW];
    logic [XW-1:0]     r_rem_x  [0:MW];
    logic [YW-1:0]     r_rem_y  [0:MW];
    logic [XW-1:0]     n_rem_x  [0:MW];
    logic [YW-1:0]     n_rem_y  [0:MW];

    jgvl_pkg::t_ctl    r_fix_ctl;
    jgvl_pkg::t_load   r_fix_load;
    logic [XW-1:0]     r_cell_x, r_next_x, n_cell_x, n_next_x;
    logic [YW-1:0]     r_cell_y, r_next_y, n_cell_y, n_next_y;
    logic [FRACTION_BITS-1:0] r_fix_frac_x, r_fix_frac_y;

    logic [XP-1:0]     n_tmp_x;
    logic [YP-1:0]     n_tmp_y;
    logic [MW-1:0]     n_mag_x, n_mag_y;

    // negative index a: a mod n = n - 1 - ((-a - 1) mod n), and -a - 1 is ~a
    assign n_mag_x = i_query_x[QW-1] ? ~i_query_x[QW-2:FRACTION_BITS]
                                     :  i_query_x[QW-2:FRACTION_BITS];
    assign n_mag_y = i_query_y[QW-1] ? ~i_query_y[QW-2:FRACTION_BITS]
                                     :  i_query_y[QW-2:FRACTION_BITS];

    always_comb begin
        n_rem_x[0] = '0;
        n_rem_y[0] = '0;
        for (int k = 1; k <= MW; k++) begin
            n_rem_x[k] = f_step_x(r_rem_x[k-1], r_mag_x[k-1][MW-k], i_width);
            n_rem_y[k] = f_step_y(r_rem_y[k-1], r_mag_y[k-1][MW-k], i_height);
        end
    end

    always_comb begin
        n_tmp_x  = XP'(i_width) - XP'(1) - XP'(r_rem_x[MW]);
        n_cell_x = r_neg_x[MW] ? n_tmp_x[XW-1:0] : r_rem_x[MW];
        n_tmp_y  = YP'(i_height) - YP'(1) - YP'(r_rem_y[MW]);
        n_cell_y = r_neg_y[MW] ? n_tmp_y[YW-1:0] : r_rem_y[MW];
    end

    // right and bottom neighbors wrap to column and row zero
    always_comb begin
        logic [XP-1:0] nx;
        logic [YP-1:0] ny;
        nx       = XP'(n_cell_x) + XP'(1);
        ny       = YP'(n_cell_y) + YP'(1);
        n_next_x = (nx >= XP'(i_width)) ? '0 : nx[XW-1:0];
        n_next_y = (ny >= YP'(i_height)) ? '0 : ny[YW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MW; k++) begin
                r_ctl[k] <= '0;
            end
            r_fix_ctl <= '0;
        end else begin
            r_ctl[0] <= i_ctl;
            for (int k = 1; k <= MW; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_fix_ctl <= r_ctl[MW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_load[0]   <= i_load;
        r_mag_x[0]  <= n_mag_x;
        r_mag_y[0]  <= n_mag_y;
        r_neg_x[0]  <= i_query_x[QW-1];
        r_neg_y[0]  <= i_query_y[QW-1];
        r_frac_x[0] <= i_query_x[FRACTION_BITS-1:0];
        r_frac_y[0] <= i_query_y[FRACTION_BITS-1:0];
        r_rem_x[0]  <= n_rem_x[0];
        r_rem_y[0]  <= n_rem_y[0];
        for (int k = 1; k <= MW; k++) begin
            r_load[k]   <= r_load[k-1];
            r_mag_x[k]  <= r_mag_x[k-1];
            r_mag_y[k]  <= r_mag_y[k-1];
            r_neg_x[k]  <= r_neg_x[k-1];
            r_neg_y[k]  <= r_neg_y[k-1];
            r_frac_x[k] <= r_frac_x[k-1];
            r_frac_y[k] <= r_frac_y[k-1];
            r_rem_x[k]  <= n_rem_x[k];
            r_rem_y[k]  <= n_rem_y[k];
        end
        r_fix_load   <= r_load[MW];
        r_cell_x     <= n_cell_x;
        r_next_x     <= n_next_x;
        r_cell_y     <= n_cell_y;
        r_next_y     <= n_next_y;
        r_fix_frac_x <= r_frac_x[MW];
        r_fix_frac_y <= r_frac_y[MW];
    end

    assign o_ctl    = r_fix_ctl;
    assign o_load   = r_fix_load;
    assign o_cell_x = r_cell_x;
    assign o_next_x = r_next_x;
    assign o_cell_y = r_cell_y;
    assign o_next_y = r_next_y;
    assign o_frac_x = r_fix_frac_x;
    assign o_frac_y = r_fix_frac_y;

endmodule

FILE: rtl/jgvl_nearest.sv
// Distance pipeline: corner offsets, squares, sums and a two level nearest select.
`timescale 1ns / 1ps

module jgvl_nearest #(
    parameter int FRACTION_BITS = jgvl_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  jgvl_pkg::t_point [3:0]           i_point,
    input  logic [FRACTION_BITS-1:0]         i_frac_x,
    input  logic [FRACTION_BITS-1:0]         i_frac_y,
    output logic                             o_strobe,
    output logic [jgvl_pkg::TYPE_W-1:0]      o_type,
    output logic [1:0]                       o_corner
);

    localparam int JF = jgvl_pkg::JITTER_FRAC_BITS;
    localparam int S  = (FRACTION_BITS > JF) ? FRACTION_BITS : JF;
    localparam int DW = S + 2;
    localparam int QW = 2 * DW;
    localparam int SW = QW + 1;
    localparam int TW = jgvl_pkg::TYPE_W;
    localparam logic signed [DW-1:0] ONE_CELL = DW'(1) << S;

    logic signed [DW-1:0] n_dx [4], n_dy [4], r_dx [4], r_dy [4];
    logic [QW-1:0]        n_sq_x [4], n_sq_y [4], r_sq_x [4], r_sq_y [4];
    logic [SW-1:0]        n_sum [4], r_sum [4];
    logic [TW-1:0]        r_d_type [4], r_sq_type [4], r_sum_type [4];
    logic [SW-1:0]        r_c_dist [2];
    logic [TW-1:0]        r_c_type [2];
    logic [1:0]           r_c_corner [2];
    logic                 r_d_valid, r_sq_valid, r_sum_valid, r_c_valid, r_out_valid;
    logic [TW-1:0]        r_out_type;
    logic [1:0]           r_out_corner;

    // offsets from the query to each corner point, all at S fraction bits;
    // corner code bit 0 selects the right column, bit 1 the bottom row
    always_comb begin
        logic signed [DW-1:0] fx, fy;
        fx = signed'(DW'(i_frac_x)) <<< (S - FRACTION_BITS);
        fy = signed'(DW'(i_frac_y)) <<< (S - FRACTION_BITS);
        for (int k = 0; k < 4; k++) begin
            n_dx[k] = (k[0] ? ONE_CELL : '0)
                    + (DW'(signed'(i_point[k].jitter_x)) <<< (S - JF)) - fx;
            n_dy[k] = (k[1] ? ONE_CELL : '0)
                    + (DW'(signed'(i_point[k].jitter_y)) <<< (S - JF)) - fy;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_sq_x[k] = QW'(r_dx[k]) * QW'(r_dx[k]);
            n_sq_y[k] = QW'(r_dy[k]) * QW'(r_dy[k]);
            n_sum[k]  = SW'(r_sq_x[k]) + SW'(r_sq_y[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid   <= 1'b0;
            r_sq_valid  <= 1'b0;
            r_sum_valid <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_valid   <= i_valid;
            r_sq_valid  <= r_d_valid;
            r_sum_valid <= r_sq_valid;
            r_c_valid   <= r_sum_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_dx[k]       <= n_dx[k];
            r_dy[k]       <= n_dy[k];
            r_d_type[k]   <= i_point[k].entry_type;
            r_sq_x[k]     <= n_sq_x[k];
            r_sq_y[k]     <= n_sq_y[k];
            r_sq_type[k]  <= r_d_type[k];
            r_sum[k]      <= n_sum[k];
            r_sum_type[k] <= r_sq_type[k];
        end
        // ties keep the earlier corner: only a strictly smaller distance wins
        if (r_sum[1] < r_sum[0]) begin
            r_c_dist[0]   <= r_sum[1];
            r_c_type[0]   <= r_sum_type[1];
            r_c_corner[0] <= jgvl_pkg::CORNER_UR;
        end else begin
            r_c_dist[0]   <= r_sum[0];
            r_c_type[0]   <= r_sum_type[0];
            r_c_corner[0] <= jgvl_pkg::CORNER_UL;
        end
        if (r_sum[3] < r_sum[2]) begin
            r_c_dist[1]   <= r_sum[3];
            r_c_type[1]   <= r_sum_type[3];
            r_c_corner[1] <= jgvl_pkg::CORNER_BR;
        end else begin
            r_c_dist[1]   <= r_sum[2];
            r_c_type[1]   <= r_sum_type[2];
            r_c_corner[1] <= jgvl_pkg::CORNER_BL;
        end
        if (r_c_dist[1] < r_c_dist[0]) begin
            r_out_type   <= r_c_type[1];
            r_out_corner <= r_c_corner[1];
        end else begin
            r_out_type   <= r_c_type[0];
            r_out_corner <= r_c_corner[0];
        end
    end

    assign o_strobe = r_out_valid;
    assign o_type   = r_out_type;
    assign o_corner = r_out_corner;

endmodule

FILE: rtl/jittered_grid_voronoi_lookup_unit.sv
// Top level of the jittered grid Voronoi lookup unit.
`timescale 1ns / 1ps

// Takes one request per clock: busy stays low and start alone issues a request.
// A query request returns its nearest corner type and code on the result ports
// for exactly one cycle, marked by o_result_strobe. Each request runs through
// the modulo pipeline, which resolves one bit of the integer cell index per
// stage, followed by the table read and the distance compare stages. Load
// requests travel the same pipeline and write the point table at the read
// stage, so every request sees exactly the loads issued before it; loads give
// no result. Results cannot be held off; the receiver must take every strobe.
// The user must write grid width and height on the configuration port while
// idle; the block does not enforce it. A size of zero acts as one and a size
// above the maximum acts as the maximum. The point table has no reset: entries
// read before being loaded are garbage.

module jittered_grid_voronoi_lookup_unit #(
    parameter int MAX_COLUMNS   = jgvl_pkg::DEFAULT_MAX_COLUMNS,
    parameter int MAX_ROWS      = jgvl_pkg::DEFAULT_MAX_ROWS,
    parameter int FRACTION_BITS = jgvl_pkg::DEFAULT_FRACTION_BITS
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // request channel
    input  logic                                    start,
    output logic                                    busy,
    input  logic                                    i_req_type,
    input  logic [jgvl_pkg::INDEX_W-1:0]            i_entry_index,
    input  logic signed [jgvl_pkg::JITTER_W-1:0]    i_jitter_x,
    input  logic signed [jgvl_pkg::JITTER_W-1:0]    i_jitter_y,
    input  logic [jgvl_pkg::TYPE_W-1:0]             i_entry_type,
    input  logic signed [jgvl_pkg::QUERY_W-1:0]     i_query_x,
    input  logic signed [jgvl_pkg::QUERY_W-1:0]     i_query_y,
    // result channel
    output logic                                    o_result_strobe,
    output logic [jgvl_pkg::TYPE_W-1:0]             o_nearest_type,
    output logic [1:0]                              o_nearest_corner,
    // configuration channel
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [jgvl_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [jgvl_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = YW + WW + 1;
    localparam int IXW   = ((AW > jgvl_pkg::INDEX_W) ? AW : jgvl_pkg::INDEX_W) + 1;
    localparam int CW    = jgvl_pkg::CFG_DATA_W + 2;

    // configuration registers
    logic [jgvl_pkg::CFG_DATA_W-1:0] r_grid_width, r_grid_height;
    logic [CW-1:0]                   n_gw, n_gh;
    logic [WW-1:0]                   n_width;
    logic [HW-1:0]                   n_height;

    // wrap pipeline outputs
    jgvl_pkg::t_ctl                  req_ctl, fix_ctl;
    jgvl_pkg::t_load                 req_load, fix_load;
    logic [XW-1:0]                   cell_x, next_x;
    logic [YW-1:0]                   cell_y, next_y;
    logic [FRACTION_BITS-1:0]        frac_x, frac_y;

    // address stage
    logic [PW-1:0]                   n_row_top, n_row_bot;
    logic                            r_a_query, r_a_we;
    logic [AW-1:0]                   r_a_waddr;
    jgvl_pkg::t_point                r_a_wdata;
    logic [AW-1:0]                   r_a_raddr [4];
    logic [FRACTION_BITS-1:0]        r_a_frac_x, r_a_frac_y;

    // table read stage
    logic                            r_b_query;
    logic [FRACTION_BITS-1:0]        r_b_frac_x, r_b_frac_y;
    jgvl_pkg::t_point [3:0]          rd_point;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= jgvl_pkg::GRID_SIZE_RESET;
            r_grid_height <= jgvl_pkg::GRID_SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                jgvl_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                jgvl_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp grid sizes into 1..max
    always_comb begin
        n_gw = CW'(r_grid_width);
        n_gh = CW'(r_grid_height);
        if (n_gw == '0) begin
            n_width = WW'(1);
        end else if (n_gw > CW'(MAX_COLUMNS)) begin
            n_width = WW'(MAX_COLUMNS);
        end else begin
            n_width = n_gw[WW-1:0];
        end
        if (n_gh == '0) begin
            n_height = HW'(1);
        end else if (n_gh > CW'(MAX_ROWS)) begin
            n_height = HW'(MAX_ROWS);
        end else begin
            n_height = n_gh[HW-1:0];
        end
    end

    assign req_ctl.valid           = start && !busy;
    assign req_ctl.is_load         = (i_req_type == jgvl_pkg::REQ_LOAD);
    assign req_load.index          = i_entry_index;
    assign req_load.jitter_x       = i_jitter_x;
    assign req_load.jitter_y       = i_jitter_y;
    assign req_load.entry_type     = i_entry_type;

    jgvl_wrap #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .MAX_ROWS      (MAX_ROWS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (req_ctl),
        .i_load    (req_load),
        .i_query_x (i_query_x),
        .i_query_y (i_query_y),
        .i_width   (n_width),
        .i_height  (n_height),
        .o_ctl     (fix_ctl),
        .o_load    (fix_load),
        .o_cell_x  (cell_x),
        .o_next_x  (next_x),
        .o_cell_y  (cell_y),
        .o_next_y  (next_y),
        .o_frac_x  (frac_x),
        .o_frac_y  (frac_y)
    );

    // row bases of the top and bottom corner pairs
    assign n_row_top = PW'(cell_y) * PW'(n_width);
    assign n_row_bot = PW'(next_y) * PW'(n_width);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_query <= 1'b0;
            r_a_we    <= 1'b0;
            r_b_query <= 1'b0;
        end else begin
            r_a_query <= fix_ctl.valid && !fix_ctl.is_load;
            // loads past the table end are dropped
            r_a_we    <= fix_ctl.valid && fix_ctl.is_load
                      && (IXW'(fix_load.index) < IXW'(DEPTH));
            r_b_query <= r_a_query;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_waddr            <= AW'(fix_load.index);
        r_a_wdata.entry_type <= fix_load.entry_type;
        r_a_wdata.jitter_x   <= fix_load.jitter_x;
        r_a_wdata.jitter_y   <= fix_load.jitter_y;
        r_a_raddr[0]         <= AW'(n_row_top + PW'(cell_x));
        r_a_raddr[1]         <= AW'(n_row_top + PW'(next_x));
        r_a_raddr[2]         <= AW'(n_row_bot + PW'(cell_x));
        r_a_raddr[3]         <= AW'(n_row_bot + PW'(next_x));
        r_a_frac_x           <= frac_x;
        r_a_frac_y           <= frac_y;
        r_b_frac_x           <= r_a_frac_x;
        r_b_frac_y           <= r_a_frac_y;
    end

    // one table copy per corner so all four corners read in the same cycle
    for (genvar g = 0; g < 4; g++) begin : g_table
        jgvl_ram #(
            .WIDTH ($bits(jgvl_pkg::t_point)),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (r_a_we),
            .i_waddr (r_a_waddr),
            .i_wdata (r_a_wdata),
            .i_raddr (r_a_raddr[g]),
            .o_rdata (rd_point[g])
        );
    end

    jgvl_nearest #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_nearest (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_b_query),
        .i_point  (rd_point),
        .i_frac_x (r_b_frac_x),
        .i_frac_y (r_b_frac_y),
        .o_strobe (o_result_strobe),
        .o_type   (o_nearest_type),
        .o_corner (o_nearest_corner)
    );

endmodule

FILE: rtl/jgvl_checker.sv
// Port level assertions for the lookup unit, bound to the top level.
`timescale 1ns / 1ps

module jgvl_checker #(
    parameter int FRACTION_BITS = jgvl_pkg::DEFAULT_FRACTION_BITS
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_result_strobe
);

    localparam int LAT = 29 - FRACTION_BITS;

    // reset flushes every request in flight
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_strobe)
        else $error("result strobe right after reset");

    // every accepted query gets its result at the fixed latency
    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == jgvl_pkg::REQ_QUERY) |-> ##LAT o_result_strobe)
        else $error("query result missing");

    // no result without a query issued at the fixed latency before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |->
            $past(start && !busy && i_req_type == jgvl_pkg::REQ_QUERY, LAT))
        else $error("result without matching query");

endmodule

bind jittered_grid_voronoi_lookup_unit jgvl_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_req_type      (i_req_type),
    .o_result_strobe (o_result_strobe)
);

FILE: tb/tb_jittered_grid_voronoi_lookup_unit.sv
// Self-checking testbench for the jittered grid Voronoi lookup unit.
`timescale 1ns / 1ps

module tb_jittered_grid_voronoi_lookup_unit;

    localparam int TABLE_DEPTH = jgvl_pkg::DEFAULT_MAX_COLUMNS * jgvl_pkg::DEFAULT_MAX_ROWS;
    // Entries loaded up front: the low rows plus the last row of a full-size grid.
    localparam int FILL_LOW  = 512;
    localparam int LAST_ROW  = TABLE_DEPTH - jgvl_pkg::DEFAULT_MAX_COLUMNS;
    // Drain wait at the end, with margin over the pipeline depth.
    localparam int DRAIN_CYCLES = 40;
    // Register indexes past the height register; writes there are dropped.
    localparam logic [jgvl_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [jgvl_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int N_DIRECTED = 12;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  start = 1'b0;
    logic                                  busy;
    logic                                  i_req_type = jgvl_pkg::REQ_QUERY;
    logic [jgvl_pkg::INDEX_W-1:0]          i_entry_index = '0;
    logic signed [jgvl_pkg::JITTER_W-1:0]  i_jitter_x = '0;
    logic signed [jgvl_pkg::JITTER_W-1:0]  i_jitter_y = '0;
    logic [jgvl_pkg::TYPE_W-1:0]           i_entry_type = '0;
    logic signed [jgvl_pkg::QUERY_W-1:0]   i_query_x = '0;
    logic signed [jgvl_pkg::QUERY_W-1:0]   i_query_y = '0;
    logic                                  o_result_strobe;
    logic [jgvl_pkg::TYPE_W-1:0]           o_nearest_type;
    logic [1:0]                            o_nearest_corner;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [jgvl_pkg::CFG_INDEX_W-1:0]      i_cfg_index = '0;
    logic [jgvl_pkg::CFG_DATA_W-1:0]       i_cfg_data = '0;

    jittered_grid_voronoi_lookup_unit DUT (.*);

    always #6 i_clk = ~i_clk;

    typedef struct {
        logic [jgvl_pkg::TYPE_W-1:0] ntype;
        logic [1:0]                  corner;
    } t_nearest;

    typedef struct {
        logic                                 req;
        logic [jgvl_pkg::INDEX_W-1:0]         idx;
        logic signed [jgvl_pkg::JITTER_W-1:0] jx;
        logic signed [jgvl_pkg::JITTER_W-1:0] jy;
        logic [jgvl_pkg::TYPE_W-1:0]          ty;
        logic signed [jgvl_pkg::QUERY_W-1:0]  qx;
        logic signed [jgvl_pkg::QUERY_W-1:0]  qy;
        bit                                   typed;
        t_nearest                             known;
    } t_stim_row;

    // Shadow copy of the point table and the size registers.
    logic [jgvl_pkg::TYPE_W-1:0]          shadow_type [TABLE_DEPTH];
    logic signed [jgvl_pkg::JITTER_W-1:0] shadow_jx [TABLE_DEPTH];
    logic signed [jgvl_pkg::JITTER_W-1:0] shadow_jy [TABLE_DEPTH];
    logic [jgvl_pkg::CFG_DATA_W-1:0]      width_reg = jgvl_pkg::GRID_SIZE_RESET;
    logic [jgvl_pkg::CFG_DATA_W-1:0]      height_reg = jgvl_pkg::GRID_SIZE_RESET;

    t_nearest  pending_nearest [$];
    int        errors = 0;
    int        idle_pct = 0;
    t_stim_row dir_rows [N_DIRECTED];

    function automatic longint eff_size(logic [jgvl_pkg::CFG_DATA_W-1:0] v, int maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : longint'(v);
    endfunction

    // Euclidean modulo of a fixed point coordinate over the grid period.
    function automatic longint wrap_q(logic signed [jgvl_pkg::QUERY_W-1:0] q, longint cells);
        longint period, m;
        period = cells << jgvl_pkg::DEFAULT_FRACTION_BITS;
        m = longint'(q) % period;
        if (m < 0) m += period;
        return m;
    endfunction

    // Nearest of the four surrounding jittered points, in 16-bit fraction units.
    function automatic t_nearest predict_nearest(logic signed [jgvl_pkg::QUERY_W-1:0] qx,
                                                 logic signed [jgvl_pkg::QUERY_W-1:0] qy);
        longint w, h, x, y, fx, fy, cr, rb, px, py, dx, dy, d, best;
        longint cx [4], cy [4], ix [4];
        t_nearest r;
        w = eff_size(width_reg, jgvl_pkg::DEFAULT_MAX_COLUMNS);
        h = eff_size(height_reg, jgvl_pkg::DEFAULT_MAX_ROWS);
        x = wrap_q(qx, w);
        y = wrap_q(qy, h);
        fx = x >>> jgvl_pkg::DEFAULT_FRACTION_BITS;
        fy = y >>> jgvl_pkg::DEFAULT_FRACTION_BITS;
        x = x <<< (16 - jgvl_pkg::DEFAULT_FRACTION_BITS);
        y = y <<< (16 - jgvl_pkg::DEFAULT_FRACTION_BITS);
        // right and bottom neighbours wrap to column and row zero
        cr = (fx + 1 >= w) ? 0 : fx + 1;
        rb = (fy + 1 >= h) ? 0 : fy + 1;
        cx = '{fx, fx + 1, fx, fx + 1};
        cy = '{fy, fy, fy + 1, fy + 1};
        ix = '{fy * w + fx, fy * w + cr, rb * w + fx, rb * w + cr};
        best = 0;
        r.corner = jgvl_pkg::CORNER_UL;
        for (int k = 0; k < 4; k++) begin
            px = (cx[k] <<< 16) + longint'(shadow_jx[ix[k] % TABLE_DEPTH]) * 256;
            py = (cy[k] <<< 16) + longint'(shadow_jy[ix[k] % TABLE_DEPTH]) * 256;
            dx = px - x;
            dy = py - y;
            d = dx * dx + dy * dy;
            // strict compare: ties keep the earlier corner
            if (k == 0 || d < best) begin
                best = d;
                r.corner = 2'(k);
            end
        end
        r.ntype = shadow_type[ix[r.corner] % TABLE_DEPTH];
        return r;
    endfunction

    // Issue one request; returns once it has been accepted.
    task automatic send_request(t_stim_row row);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_req_type    <= row.req;
        i_entry_index <= row.idx;
        i_jitter_x    <= row.jx;
        i_jitter_y    <= row.jy;
        i_entry_type  <= row.ty;
        i_query_x     <= row.qx;
        i_query_y     <= row.qy;
        do @(posedge i_clk); while (busy);
        // accepted at this edge: update the shadow in request order
        if (row.req == jgvl_pkg::REQ_LOAD) begin
            shadow_type[row.idx] = row.ty;
            shadow_jx[row.idx]   = row.jx;
            shadow_jy[row.idx]   = row.jy;
        end else if (row.typed) begin
            pending_nearest.push_back(row.known);
        end else begin
            pending_nearest.push_back(predict_nearest(row.qx, row.qy));
        end
    endtask

    // Register writes only with the pipeline drained.
    task automatic write_reg(logic [jgvl_pkg::CFG_INDEX_W-1:0] idx,
                             logic [jgvl_pkg::CFG_DATA_W-1:0] val);
        start <= 1'b0;
        wait (pending_nearest.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == jgvl_pkg::REG_GRID_WIDTH) width_reg = val;
        else if (idx == jgvl_pkg::REG_GRID_HEIGHT) height_reg = val;
    endtask

    function automatic logic signed [jgvl_pkg::JITTER_W-1:0] rand_jitter();
        if ($urandom_range(9) == 0) return jgvl_pkg::JITTER_W'($urandom);
        return jgvl_pkg::JITTER_W'($urandom_range(244) - 122);
    endfunction

    // Mostly near the grid, sometimes anywhere in the 21-bit range.
    function automatic logic signed [jgvl_pkg::QUERY_W-1:0] rand_coord(longint cells);
        longint span;
        span = cells << jgvl_pkg::DEFAULT_FRACTION_BITS;
        if ($urandom_range(3) == 0) return jgvl_pkg::QUERY_W'($urandom);
        return jgvl_pkg::QUERY_W'(longint'($urandom_range(4 * span)) - 2 * span);
    endfunction

    function automatic t_stim_row rand_row();
        t_stim_row r;
        r = '{default: '0};
        r.req = ($urandom_range(99) < 30) ? jgvl_pkg::REQ_LOAD : jgvl_pkg::REQ_QUERY;
        r.idx = jgvl_pkg::INDEX_W'($urandom);
        r.jx  = rand_jitter();
        r.jy  = rand_jitter();
        r.ty  = jgvl_pkg::TYPE_W'($urandom);
        r.qx  = rand_coord(eff_size(width_reg, jgvl_pkg::DEFAULT_MAX_COLUMNS));
        r.qy  = rand_coord(eff_size(height_reg, jgvl_pkg::DEFAULT_MAX_ROWS));
        return r;
    endfunction

    // Result checker: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        t_nearest exp_n;
        if (i_rst_n && o_result_strobe) begin
            if (pending_nearest.size() == 0) begin
                $display("%0t: unexpected result type=%h corner=%0d", $time,
                         o_nearest_type, o_nearest_corner);
                errors++;
            end else begin
                exp_n = pending_nearest.pop_front();
                if (o_nearest_type !== exp_n.ntype) begin
                    $display("%0t: nearest_type expected %h actual %h", $time,
                             exp_n.ntype, o_nearest_type);
                    errors++;
                end
                if (o_nearest_corner !== exp_n.corner) begin
                    $display("%0t: nearest_corner expected %0d actual %0d", $time,
                             exp_n.corner, o_nearest_corner);
                    errors++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_stim_row row;
        // every grid below covers at most FILL_LOW entries
        int w_set [8] = '{64, 1, 0, 127, 5, 64, 7, 37};
        int h_set [8] = '{8, 1, 0, 5, 100, 1, 64, 13};

        // Directed rows: typed results only where they are obvious.
        dir_rows[0]  = '{jgvl_pkg::REQ_LOAD, 12'd0, 8'sd0, 8'sd0, 8'h11, '0, '0, 0, '{0, 0}};
        dir_rows[1]  = '{jgvl_pkg::REQ_LOAD, 12'd1, 8'sd0, 8'sd0, 8'h22, '0, '0, 0, '{0, 0}};
        // query on a point exactly: distance zero at UL
        dir_rows[2]  = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, 21'sd0, 21'sd0, 1,
                         '{8'h11, jgvl_pkg::CORNER_UL}};
        // halfway between UL and UR: tie goes to UL
        dir_rows[3]  = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, 21'sd128, 21'sd0, 1,
                         '{8'h11, jgvl_pkg::CORNER_UL}};
        dir_rows[4]  = '{jgvl_pkg::REQ_LOAD, 12'd1, -8'sd122, 8'sd0, 8'h3C, '0, '0, 0,
                         '{0, 0}};
        // UR pulled left to x=0.523 now wins
        dir_rows[5]  = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, 21'sd128, 21'sd0, 1,
                         '{8'h3C, jgvl_pkg::CORNER_UR}};
        // jitter at full 8-bit extremes, stored as given
        dir_rows[6]  = '{jgvl_pkg::REQ_LOAD, 12'd4095, 8'sh7F, -8'sd128, 8'hFF, '0, '0, 0,
                         '{0, 0}};
        dir_rows[7]  = '{jgvl_pkg::REQ_LOAD, 12'd63, -8'sd128, 8'sh7F, 8'h00, '0, '0, 0,
                         '{0, 0}};
        // last column and row: neighbours wrap to zero
        dir_rows[8]  = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, 21'sd16320, 21'sd16320, 0,
                         '{0, 0}};
        // negative coordinates wrap
        dir_rows[9]  = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, -21'sd1, -21'sd1, 0, '{0, 0}};
        // coordinate extremes
        dir_rows[10] = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, -21'sd1048576, 21'sd1048575, 0,
                         '{0, 0}};
        dir_rows[11] = '{jgvl_pkg::REQ_QUERY, '0, '0, '0, '0, 21'sd1048575, -21'sd1048576, 0,
                         '{0, 0}};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every entry any query can reach: the low rows for the small grids,
        // plus the last row that the wrapping directed queries touch.
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i < FILL_LOW || i >= LAST_ROW) begin
                row = rand_row();
                row.req = jgvl_pkg::REQ_LOAD;
                row.idx = jgvl_pkg::INDEX_W'(i);
                send_request(row);
            end
        end
        for (int i = 0; i < N_DIRECTED; i++) send_request(dir_rows[i]);

        // Spare register indexes must be ignored.
        write_reg(REG_SPARE_2, jgvl_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, jgvl_pkg::CFG_DATA_W'($urandom));

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(jgvl_pkg::REG_GRID_WIDTH, jgvl_pkg::CFG_DATA_W'(w_set[ph]));
            write_reg(jgvl_pkg::REG_GRID_HEIGHT, jgvl_pkg::CFG_DATA_W'(h_set[ph]));
            for (int i = 0; i < 133; i++) begin
                // rotate idling every 50 requests, back-to-back stretches included
                case ((i / 50) % 3)
                    0: idle_pct = 0;
                    1: idle_pct = 83;
                    default: idle_pct = 37;
                endcase
                send_request(rand_row());
            end
        end

        start <= 1'b0;
        wait (pending_nearest.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

endmodule
